// File: rtl/lrd_pkg.sv
// lrd_pkg: shared types, codes and constants of the log record deframer
// no dependencies; compiled first

package lrd_pkg;

  // crc-32, reflected form
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  // configuration port
  localparam int CFG_DATA_W  = 21;
  localparam int CFG_INDEX_W = 2;
  localparam int ID_LEN_W    = 16;
  localparam int NAME_LEN_W  = 16;
  localparam int DATA_LEN_W  = 21;

  localparam logic [ID_LEN_W-1:0]   MAX_ID_RESET      = ID_LEN_W'(256);
  localparam logic [NAME_LEN_W-1:0] MAX_NAME_RESET    = NAME_LEN_W'(256);
  localparam logic [DATA_LEN_W-1:0] MAX_PAYLOAD_RESET = DATA_LEN_W'(1024 * 1024);

  localparam int PAYLOAD_COUNT_WIDTH_DEF = 21;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MAX_ID      = 2'd0,
    CFG_MAX_NAME    = 2'd1,
    CFG_MAX_PAYLOAD = 2'd2
  } lrd_cfg_index_t;

  // parse phase; the value doubles as the field tag
  typedef enum logic [3:0] {
    PH_TYPE    = 4'd0,
    PH_IDLEN   = 4'd1,
    PH_ID      = 4'd2,
    PH_NAMELEN = 4'd3,
    PH_NAME    = 4'd4,
    PH_DATALEN = 4'd5,
    PH_DATA    = 4'd6,
    PH_TIME    = 4'd7,
    PH_CRC     = 4'd8
  } lrd_phase_t;

  typedef enum logic [2:0] {
    ST_BUSY      = 3'd0,
    ST_GOOD      = 3'd1,
    ST_ID_LONG   = 3'd2,
    ST_NAME_LONG = 3'd3,
    ST_DATA_LONG = 3'd4,
    ST_TRUNC     = 3'd5,
    ST_CRC_BAD   = 3'd6
  } lrd_status_t;

  typedef struct packed {
    logic [ID_LEN_W-1:0]   max_id;
    logic [NAME_LEN_W-1:0] max_name;
    logic [DATA_LEN_W-1:0] max_payload;
  } lrd_limits_t;

  typedef struct packed {
    logic [3:0]  field_tag;
    logic [7:0]  field_byte;
    logic [7:0]  record_kind;
    logic [63:0] record_time;
    logic [31:0] stored_check;
    lrd_status_t status;
    logic        record_end;
  } lrd_result_t;

endpackage

// File: rtl/lrd_in_if.sv
// lrd_in_if: byte stream channel (valid/ready plus payload)
// no dependencies

interface lrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       buffer_end;

  modport source (output valid, output in_byte, output buffer_end, input ready);
  modport sink   (input valid, input in_byte, input buffer_end, output ready);
endinterface

// File: rtl/lrd_out_if.sv
// lrd_out_if: tagged field channel (valid/ready plus payload)
// no dependencies

interface lrd_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  field_tag;
  logic [7:0]  field_byte;
  logic [7:0]  record_kind;
  logic [63:0] record_time;
  logic [31:0] stored_check;
  logic [2:0]  status;
  logic        record_end;

  modport source (output valid, output field_tag, output field_byte, output record_kind,
                  output record_time, output stored_check, output status,
                  output record_end, input ready);
  modport sink   (input valid, input field_tag, input field_byte, input record_kind,
                  input record_time, input stored_check, input status,
                  input record_end, output ready);
endinterface

// File: rtl/lrd_crc_byte.sv
// lrd_crc_byte: one-byte update of a reflected crc-32
// depends on lrd_pkg

module lrd_crc_byte
  import lrd_pkg::*;
(
  input  logic [31:0] crc_in,
  input  logic [7:0]  data,
  output logic [31:0] crc_out
);

  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    crc_out = c;
  end

endmodule

// File: rtl/lrd_parser.sv
// lrd_parser: record state, field tagging, length checks and crc compare
// depends on lrd_pkg and lrd_crc_byte

module lrd_parser
  import lrd_pkg::*;
#(
  parameter int PAYLOAD_COUNT_WIDTH = PAYLOAD_COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  in_byte,
  input  logic        buffer_end,
  input  lrd_limits_t limits,
  output lrd_result_t result
);

  localparam int CW = PAYLOAD_COUNT_WIDTH;
  localparam logic [31:0] COUNT_MASK = 32'((64'd1 << CW) - 64'd1);

  lrd_phase_t  phase, phase_next;
  logic [CW-1:0] byte_count, byte_count_next;
  logic [31:0] field_length, field_length_next;
  logic [31:0] running_crc, running_crc_next;
  logic [7:0]  kind_latch, kind_latch_next;
  logic [63:0] time_latch, time_latch_next;
  logic [31:0] check_latch, check_latch_next;
  logic        discarding, discarding_next;

  logic [31:0] crc_upd;
  logic [CW-1:0] cnt_inc;
  logic [31:0] len_asm;
  logic [31:0] cap_id, cap_name, cap_payload;

  lrd_crc_byte u_crc (
    .crc_in  (running_crc),
    .data    (in_byte),
    .crc_out (crc_upd)
  );

  assign cnt_inc = byte_count + CW'(1);
  assign len_asm = (byte_count == '0) ? {24'd0, in_byte}
                 : field_length | ({24'd0, in_byte} << {byte_count[1:0], 3'b000});

  // limits are capped at the largest count the position counter holds
  assign cap_id      = ({16'd0, limits.max_id} > COUNT_MASK) ? COUNT_MASK
                     : {16'd0, limits.max_id};
  assign cap_name    = ({16'd0, limits.max_name} > COUNT_MASK) ? COUNT_MASK
                     : {16'd0, limits.max_name};
  assign cap_payload = ({11'd0, limits.max_payload} > COUNT_MASK) ? COUNT_MASK
                     : {11'd0, limits.max_payload};

  always_comb begin
    logic [3:0]  tag;
    lrd_status_t status;
    lrd_status_t err;
    logic        done;
    logic        rend;

    phase_next        = phase;
    byte_count_next   = byte_count;
    field_length_next = field_length;
    running_crc_next  = running_crc;
    kind_latch_next   = kind_latch;
    time_latch_next   = time_latch;
    check_latch_next  = check_latch;
    discarding_next   = discarding;
    tag    = phase;
    status = ST_BUSY;
    err    = ST_BUSY;
    done   = 1'b0;
    rend   = 1'b0;

    if (discarding) begin
      tag = PH_TYPE;
      if (buffer_end) begin
        discarding_next   = 1'b0;
        phase_next        = PH_TYPE;
        byte_count_next   = '0;
        field_length_next = '0;
        running_crc_next  = CRC_ONES;
      end
    end else begin
      if (phase != PH_CRC) begin
        running_crc_next = crc_upd;
      end
      case (phase)
        PH_IDLEN: begin
          field_length_next = len_asm;
          byte_count_next   = cnt_inc;
          if (cnt_inc == CW'(2)) begin
            if (len_asm > cap_id) begin
              err = ST_ID_LONG;
            end else begin
              byte_count_next = '0;
              phase_next      = (len_asm != '0) ? PH_ID : PH_NAMELEN;
            end
          end
        end
        PH_ID: begin
          byte_count_next = cnt_inc;
          if (32'(cnt_inc) == field_length) begin
            byte_count_next = '0;
            phase_next      = PH_NAMELEN;
          end
        end
        PH_NAMELEN: begin
          field_length_next = len_asm;
          byte_count_next   = cnt_inc;
          if (cnt_inc == CW'(2)) begin
            if (len_asm > cap_name) begin
              err = ST_NAME_LONG;
            end else begin
              byte_count_next = '0;
              phase_next      = (len_asm != '0) ? PH_NAME : PH_DATALEN;
            end
          end
        end
        PH_NAME: begin
          byte_count_next = cnt_inc;
          if (32'(cnt_inc) == field_length) begin
            byte_count_next = '0;
            phase_next      = PH_DATALEN;
          end
        end
        PH_DATALEN: begin
          field_length_next = len_asm;
          byte_count_next   = cnt_inc;
          if (cnt_inc == CW'(4)) begin
            if (len_asm > cap_payload) begin
              err = ST_DATA_LONG;
            end else begin
              byte_count_next = '0;
              phase_next      = (len_asm != '0) ? PH_DATA : PH_TIME;
            end
          end
        end
        PH_DATA: begin
          byte_count_next = cnt_inc;
          if (32'(cnt_inc) == field_length) begin
            byte_count_next = '0;
            phase_next      = PH_TIME;
          end
        end
        PH_TIME: begin
          time_latch_next = {in_byte, time_latch[63:8]};
          byte_count_next = cnt_inc;
          if (cnt_inc == CW'(8)) begin
            byte_count_next = '0;
            phase_next      = PH_CRC;
          end
        end
        PH_CRC: begin
          check_latch_next = {in_byte, check_latch[31:8]};
          byte_count_next  = cnt_inc;
          if (cnt_inc == CW'(4)) begin
            done   = 1'b1;
            status = ((running_crc ^ CRC_ONES) == check_latch_next) ? ST_GOOD : ST_CRC_BAD;
          end
        end
        default: begin
          tag             = PH_TYPE;
          kind_latch_next = in_byte;
          byte_count_next = '0;
          phase_next      = PH_IDLEN;
        end
      endcase

      if (!done && err == ST_BUSY && buffer_end) begin
        err = ST_TRUNC;
      end
      if (err != ST_BUSY) begin
        status = err;
      end
      if (done || err != ST_BUSY) begin
        rend              = 1'b1;
        phase_next        = PH_TYPE;
        byte_count_next   = '0;
        field_length_next = '0;
        running_crc_next  = CRC_ONES;
        discarding_next   = (status != ST_GOOD) && !buffer_end;
      end
    end

    result.field_tag    = tag;
    result.field_byte   = in_byte;
    result.record_kind  = kind_latch_next;
    result.record_time  = time_latch_next;
    result.stored_check = check_latch_next;
    result.status       = status;
    result.record_end   = rend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_TYPE;
      byte_count   <= '0;
      field_length <= '0;
      running_crc  <= CRC_ONES;
      kind_latch   <= '0;
      time_latch   <= '0;
      check_latch  <= '0;
      discarding   <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      field_length <= field_length_next;
      running_crc  <= running_crc_next;
      kind_latch   <= kind_latch_next;
      time_latch   <= time_latch_next;
      check_latch  <= check_latch_next;
      discarding   <= discarding_next;
    end
  end

endmodule

// File: rtl/log_record_deframer_crc32_check.sv
// log_record_deframer_crc32_check: top level with config registers and output register
// latency: a byte accepted at one edge shows its tagged result on the next cycle
// throughput: one byte per cycle unless the sink stalls; single-pass crc, length compare
// reset (rst, synchronous): limits return to 256/256/1 MiB, parser expects a type byte
// depends on lrd_pkg, lrd_in_if, lrd_out_if, lrd_parser

module log_record_deframer_crc32_check
  import lrd_pkg::*;
#(
  parameter int PAYLOAD_COUNT_WIDTH = PAYLOAD_COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  lrd_in_if.sink                 byte_stream,
  lrd_out_if.source              field_stream
);

  lrd_limits_t limits;
  lrd_result_t result;
  lrd_result_t out_reg;
  logic        out_valid;
  logic        accept;

  // configuration registers; writes to an unused index are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      limits.max_id      <= MAX_ID_RESET;
      limits.max_name    <= MAX_NAME_RESET;
      limits.max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg_we) begin
      case (lrd_cfg_index_t'(cfg_index))
        CFG_MAX_ID:      limits.max_id      <= cfg_data[ID_LEN_W-1:0];
        CFG_MAX_NAME:    limits.max_name    <= cfg_data[NAME_LEN_W-1:0];
        CFG_MAX_PAYLOAD: limits.max_payload <= cfg_data[DATA_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // take a new byte whenever the output register is empty or being drained
  assign byte_stream.ready = !out_valid || field_stream.ready;
  assign accept            = byte_stream.valid && byte_stream.ready;

  // parser: all per-byte work in one pass, state advances only on a transaction
  lrd_parser #(
    .PAYLOAD_COUNT_WIDTH (PAYLOAD_COUNT_WIDTH)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .in_byte    (byte_stream.in_byte),
    .buffer_end (byte_stream.buffer_end),
    .limits     (limits),
    .result     (result)
  );

  // output register: holds a result while the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (field_stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      out_reg <= result;
    end
  end

  assign field_stream.valid        = out_valid;
  assign field_stream.field_tag    = out_reg.field_tag;
  assign field_stream.field_byte   = out_reg.field_byte;
  assign field_stream.record_kind  = out_reg.record_kind;
  assign field_stream.record_time  = out_reg.record_time;
  assign field_stream.stored_check = out_reg.stored_check;
  assign field_stream.status       = out_reg.status;
  assign field_stream.record_end   = out_reg.record_end;

endmodule

// File: bench/lrd_field_checker.sv
// lrd_field_checker: watches the byte and field channels, predicts every tagged field
// and compares it with what the deframer returns; depends on lrd_pkg, lrd_in_if, lrd_out_if

module lrd_field_checker
  import lrd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  lrd_in_if                      byte_stream,
  lrd_out_if                     field_stream,
  output int                     mismatches,
  output int                     pending,
  output int                     parsed,
  output int                     good_records,
  output int                     error_reports
);

  localparam int CW = PAYLOAD_COUNT_WIDTH_DEF;
  localparam logic [31:0] COUNT_CAP = 32'((64'd1 << CW) - 1);

  lrd_limits_t   limits;
  lrd_phase_t    phase;
  logic [CW-1:0] pos;
  logic [31:0]   field_len;
  logic [31:0]   crc;
  logic [7:0]    kind;
  logic [63:0]   stamp;
  logic [31:0]   stored_crc;
  logic          skipping;

  lrd_result_t expected_fields[$];

  function automatic logic [31:0] capped(logic [31:0] lim);
    return (lim < COUNT_CAP) ? lim : COUNT_CAP;
  endfunction

  function automatic void new_record();
    phase     = PH_TYPE;
    pos       = '0;
    field_len = '0;
    crc       = CRC_ONES;
  endfunction

  // little-endian length assembly; true once the field is complete
  function automatic bit take_len_byte(logic [7:0] b, int unsigned size);
    if (pos == '0) field_len = {24'h0, b};
    else field_len = field_len | ({24'h0, b} << (8 * pos[1:0]));
    pos = pos + 1'b1;
    return pos == CW'(size);
  endfunction

  function automatic void take_body_byte(lrd_phase_t next_phase);
    pos = pos + 1'b1;
    if (32'(pos) == field_len) begin
      pos   = '0;
      phase = next_phase;
    end
  endfunction

  function automatic lrd_result_t parse_byte(logic [7:0] b, logic last);
    lrd_result_t r;
    lrd_status_t st;
    logic        done;
    r = '0;
    r.field_tag = phase;
    st = ST_BUSY;
    done = 1'b0;
    if (skipping) begin
      r.field_tag = PH_TYPE;
      if (last) begin
        skipping = 1'b0;
        new_record();
      end
    end else begin
      if (phase != PH_CRC) begin
        crc = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++) crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      end
      case (phase)
        PH_IDLEN: if (take_len_byte(b, 2)) begin
          if (field_len > capped(32'(limits.max_id))) st = ST_ID_LONG;
          else begin
            pos   = '0;
            phase = (field_len != 0) ? PH_ID : PH_NAMELEN;
          end
        end
        PH_ID: take_body_byte(PH_NAMELEN);
        PH_NAMELEN: if (take_len_byte(b, 2)) begin
          if (field_len > capped(32'(limits.max_name))) st = ST_NAME_LONG;
          else begin
            pos   = '0;
            phase = (field_len != 0) ? PH_NAME : PH_DATALEN;
          end
        end
        PH_NAME: take_body_byte(PH_DATALEN);
        PH_DATALEN: if (take_len_byte(b, 4)) begin
          if (field_len > capped(32'(limits.max_payload))) st = ST_DATA_LONG;
          else begin
            pos   = '0;
            phase = (field_len != 0) ? PH_DATA : PH_TIME;
          end
        end
        PH_DATA: take_body_byte(PH_TIME);
        PH_TIME: begin
          stamp = {b, stamp[63:8]};
          pos = pos + 1'b1;
          if (pos == CW'(8)) begin
            pos   = '0;
            phase = PH_CRC;
          end
        end
        PH_CRC: begin
          stored_crc = {b, stored_crc[31:8]};
          pos = pos + 1'b1;
          if (pos == CW'(4)) begin
            done = 1'b1;
            st = ((crc ^ CRC_ONES) == stored_crc) ? ST_GOOD : ST_CRC_BAD;
          end
        end
        default: begin
          r.field_tag = PH_TYPE;
          kind  = b;
          pos   = '0;
          phase = PH_IDLEN;
        end
      endcase
      // buffer end mid-record, unless something else already ended it
      if (!done && st == ST_BUSY && last) st = ST_TRUNC;
      if (st != ST_BUSY) begin
        r.record_end = 1'b1;
        new_record();
        skipping = (st != ST_GOOD) && !last;
      end
    end
    r.field_byte   = b;
    r.record_kind  = kind;
    r.record_time  = stamp;
    r.stored_check = stored_crc;
    r.status       = st;
    return r;
  endfunction

  function automatic int diff_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    lrd_result_t want;
    if (rst) begin
      limits     = '{MAX_ID_RESET, MAX_NAME_RESET, MAX_PAYLOAD_RESET};
      kind       = '0;
      stamp      = '0;
      stored_crc = '0;
      skipping   = 1'b0;
      new_record();
      expected_fields.delete();
      mismatches    = 0;
      parsed        = 0;
      good_records  = 0;
      error_reports = 0;
    end else begin
      // results leave before this edge's byte can produce one
      if (field_stream.valid && field_stream.ready) begin
        if (expected_fields.size() == 0) begin
          $error("field transaction with nothing expected: tag %0d byte %0h",
                 field_stream.field_tag, field_stream.field_byte);
          mismatches++;
        end else begin
          want = expected_fields.pop_front();
          mismatches += diff_field("field_tag", want.field_tag, field_stream.field_tag);
          mismatches += diff_field("field_byte", want.field_byte, field_stream.field_byte);
          mismatches += diff_field("record_kind", want.record_kind, field_stream.record_kind);
          mismatches += diff_field("record_time", want.record_time, field_stream.record_time);
          mismatches += diff_field("stored_check", want.stored_check,
                                   field_stream.stored_check);
          mismatches += diff_field("status", want.status, field_stream.status);
          mismatches += diff_field("record_end", want.record_end, field_stream.record_end);
        end
      end
      if (byte_stream.valid && byte_stream.ready) begin
        if (!skipping) parsed++;
        want = parse_byte(byte_stream.in_byte, byte_stream.buffer_end);
        expected_fields.insert(expected_fields.size(), want);
        if (want.status == ST_GOOD) good_records++;
        else if (want.status != ST_BUSY) error_reports++;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_ID:      limits.max_id      = cfg_data[ID_LEN_W-1:0];
          CFG_MAX_NAME:    limits.max_name    = cfg_data[NAME_LEN_W-1:0];
          CFG_MAX_PAYLOAD: limits.max_payload = cfg_data[DATA_LEN_W-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_fields.size();
  end

endmodule

// File: bench/testbench.sv
// testbench: drives byte buffers of log records into the deframer under several limit
// settings; depends on lrd_pkg, lrd_in_if, lrd_out_if, the deframer and lrd_field_checker

module testbench;
  import lrd_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  lrd_cfg_index_t        cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lrd_in_if  byte_ch ();
  lrd_out_if field_ch ();

  int mismatches;
  int pending;
  int parsed;
  int good_records;
  int error_reports;

  // limits as last written, used to decide which records overrun them
  int unsigned lim_id      = 256;
  int unsigned lim_name    = 256;
  int unsigned lim_payload = 1024 * 1024;

  // buffer under construction and the running crc of its current record
  logic [7:0]  buffer_bytes[$];
  logic [31:0] rec_crc;

  bit calm;  // final stretch: neither side idles
  bit held;  // long receiver hold-off already done

  log_record_deframer_crc32_check dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .byte_stream  (byte_ch),
    .field_stream (field_ch)
  );

  lrd_field_checker field_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .byte_stream   (byte_ch),
    .field_stream  (field_ch),
    .mismatches    (mismatches),
    .pending       (pending),
    .parsed        (parsed),
    .good_records  (good_records),
    .error_reports (error_reports)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // appends one byte to the buffer and folds it into the record crc
  function automatic void put(logic [7:0] b);
    buffer_bytes.insert(buffer_bytes.size(), b);
    rec_crc = rec_crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++)
      rec_crc = rec_crc[0] ? ((rec_crc >> 1) ^ CRC_POLY) : (rec_crc >> 1);
  endfunction

  // mostly short fields, now and then one sitting right on the limit or a few hundred long
  function automatic int unsigned pick_len(int unsigned lim);
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0 && lim <= 300) return lim;
    if (roll == 1) return $urandom_range(0, (lim < 300) ? lim : 300);
    return $urandom_range(0, (lim < 5) ? lim : 5);
  endfunction

  // one past the limit or anywhere above it
  function automatic int unsigned over_limit(int unsigned lim, int unsigned ceiling);
    if ($urandom_range(0, 1) == 0) return lim + 1;
    return $urandom_range(lim + 1, ceiling);
  endfunction

  // builds one record; a length over its limit ends the record right after the
  // length field, since the block drops the rest anyway; err_at marks that byte
  task automatic add_record(input int unsigned id_len, input int unsigned name_len,
                            input int unsigned pay_len, input bit bad_crc,
                            output int err_at);
    logic [31:0] stored;
    err_at = -1;
    rec_crc = CRC_ONES;
    put(8'($urandom));
    put(id_len[7:0]);
    put(id_len[15:8]);
    if (id_len > lim_id) begin
      err_at = buffer_bytes.size() - 1;
      return;
    end
    repeat (id_len) put(8'($urandom));
    put(name_len[7:0]);
    put(name_len[15:8]);
    if (name_len > lim_name) begin
      err_at = buffer_bytes.size() - 1;
      return;
    end
    repeat (name_len) put(8'($urandom));
    put(pay_len[7:0]);
    put(pay_len[15:8]);
    put(pay_len[23:16]);
    put(pay_len[31:24]);
    if (pay_len > lim_payload) begin
      err_at = buffer_bytes.size() - 1;
      return;
    end
    repeat (pay_len) put(8'($urandom));
    repeat (8) put(8'($urandom));
    stored = ~rec_crc;
    if (bad_crc) stored = stored ^ (32'h1 << $urandom_range(0, 31));
    for (int k = 0; k < 4; k++) buffer_bytes.insert(buffer_bytes.size(), stored[8*k +: 8]);
  endtask

  // one byte transaction, sometimes after an idle burst
  task automatic offer_byte(input logic [7:0] b, input logic last);
    if (!calm && $urandom_range(0, 11) == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    byte_ch.valid      <= 1'b1;
    byte_ch.in_byte    <= b;
    byte_ch.buffer_end <= last;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
  endtask

  // sends the whole buffer, marking its last byte as the buffer end
  task automatic flush_buffer();
    foreach (buffer_bytes[i]) offer_byte(buffer_bytes[i], i == buffer_bytes.size() - 1);
  endtask

  // mostly well-formed records with random content; some overrun a limit, carry a
  // wrong crc or get cut short, and a few buffers are plain line noise
  task automatic send_random_buffer();
    int          err_at;
    int          cut;
    int          n;
    int unsigned plan;
    int unsigned id_len;
    int unsigned name_len;
    int unsigned pay_len;
    buffer_bytes.delete();
    cut = -1;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 24)) buffer_bytes.insert(buffer_bytes.size(), 8'($urandom));
    end else begin
      n = $urandom_range(1, 3);
      for (int r = 0; r < n && cut < 0; r++) begin
        plan     = $urandom_range(0, 19);
        id_len   = pick_len(lim_id);
        name_len = pick_len(lim_name);
        pay_len  = pick_len(lim_payload);
        if (plan == 0 && lim_id < 32'hFFFF) id_len = over_limit(lim_id, 32'hFFFF);
        if (plan == 1 && lim_name < 32'hFFFF) name_len = over_limit(lim_name, 32'hFFFF);
        if (plan == 2) pay_len = over_limit(lim_payload, 32'hFFFF_FFFF);
        add_record(id_len, name_len, pay_len, plan == 3 || plan == 4, err_at);
        // buffer end on the overrun length byte: the limit wins over truncation
        if (err_at >= 0 && $urandom_range(0, 2) == 0) cut = err_at;
      end
      // truncation anywhere in the buffer
      if (cut < 0 && $urandom_range(0, 6) == 0) cut = $urandom_range(0, buffer_bytes.size() - 1);
      if (cut >= 0) buffer_bytes = buffer_bytes[0:cut];
    end
    flush_buffer();
  endtask

  // drops valid and waits until every expected field transaction has come back
  task automatic wait_idle();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // writes all three limits on consecutive edges, enable held high throughout
  task automatic set_limits(input int unsigned id_max, input int unsigned name_max,
                            input int unsigned payload_max);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_ID;
    cfg_data  <= CFG_DATA_W'(id_max);
    @(posedge clk);
    cfg_index <= CFG_MAX_NAME;
    cfg_data  <= CFG_DATA_W'(name_max);
    @(posedge clk);
    cfg_index <= CFG_MAX_PAYLOAD;
    cfg_data  <= CFG_DATA_W'(payload_max);
    @(posedge clk);
    cfg_we <= 1'b0;
    lim_id      = id_max;
    lim_name    = name_max;
    lim_payload = payload_max;
  endtask

  // receiver: random stall bursts, one long hold-off so the block backs up and
  // stalls its input while bytes keep being offered
  initial begin : receiver
    forever begin
      if (!held && parsed >= 600) begin
        held = 1'b1;
        field_ch.ready <= 1'b0;
        repeat (250) @(posedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        field_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        field_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int err_at;
    int goal;
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_MAX_ID;
    cfg_data           <= '0;
    byte_ch.valid      <= 1'b0;
    byte_ch.in_byte    <= '0;
    byte_ch.buffer_end <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed, reset limits: a lone type byte that is also the buffer end
    buffer_bytes = '{8'hFF};
    flush_buffer();
    // id length 257 over the 256 limit, then one discarded byte closing the buffer
    buffer_bytes = '{8'h00, 8'h01, 8'h01, 8'hAA};
    flush_buffer();
    // shortest good record: all variable fields empty, buffer end on the last crc byte
    buffer_bytes.delete();
    add_record(0, 0, 0, 1'b0, err_at);
    flush_buffer();

    // random buffers under a series of limit settings, extremes included
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      case (p)
        0: set_limits(0, 0, 0);
        1: set_limits(32'hFFFF, 32'hFFFF, 1024 * 1024);
        2: set_limits(3, 7, 12);
        3: set_limits(1, 0, 32'h1F_FFFF);
        4: set_limits($urandom_range(0, 16), $urandom_range(0, 16), $urandom_range(0, 16));
        default: set_limits(256, 256, 1024 * 1024);
      endcase
      calm = (p == 5);
      goal = parsed + 180;
      while (parsed < goal) send_random_buffer();
    end
    wait_idle();

    $display("covered %0d parsed bytes over directed buffers and six limit settings",
             parsed);
    $display("%0d good records and %0d error reports checked", good_records, error_reports);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin : watchdog
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
